// ===== rtl/drik_pkg.sv =====
//------------------------------------------------------------------------------
// drik_pkg
// Shared types, constants and the CORDIC angle table for the delta robot
// inverse kinematics pipeline.
//------------------------------------------------------------------------------
package drik_pkg;

   localparam int PosWidth   = 15;
   localparam int AngleWidth = 17;
   localparam int UvWidth    = 35;   // u and v span
   localparam int WWidth     = 34;   // w span
   localparam int RootWidth  = 36;
   localparam int CordWidth  = 40;   // CORDIC x/y width
   localparam int ZWidth     = 26;   // accumulated angle, 1/65536 degree
   localparam int MaxSteps   = 32;

   localparam logic signed [17:0] Sqrt3Q16   = 18'sd113512;
   localparam logic signed [17:0] AngleLimit = 18'sd46080;

   localparam logic [2:0] CSR_OFFSET_A = 3'd0;
   localparam logic [2:0] CSR_OFFSET_B = 3'd1;
   localparam logic [2:0] CSR_OFFSET_C = 3'd2;
   localparam logic [2:0] CSR_ACTIVE   = 3'd3;
   localparam logic [2:0] CSR_PASSIVE  = 3'd4;

   // One arm's terms after the front end.
   typedef struct packed {
      logic signed [UvWidth-1:0] u;
      logic signed [UvWidth-1:0] v;
      logic signed [WWidth-1:0]  w;
   } arm_terms_type;

   function automatic logic signed [ZWidth-1:0] atan_entry(input int i);
      logic signed [ZWidth-1:0] r;
      begin
         case (i)
            0: r = 26'sd2949120;   1: r = 26'sd1740967;
            2: r = 26'sd919879;    3: r = 26'sd466945;
            4: r = 26'sd234379;    5: r = 26'sd117304;
            6: r = 26'sd58666;     7: r = 26'sd29335;
            8: r = 26'sd14668;     9: r = 26'sd7334;
            10: r = 26'sd3667;     11: r = 26'sd1833;
            12: r = 26'sd917;      13: r = 26'sd458;
            14: r = 26'sd229;      15: r = 26'sd115;
            16: r = 26'sd57;       17: r = 26'sd29;
            18: r = 26'sd14;       19: r = 26'sd7;
            20: r = 26'sd4;        21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/drik_front.sv =====
//------------------------------------------------------------------------------
// drik_front
// Forms u, v and w for the three arms over three register stages.
//------------------------------------------------------------------------------
module drik_front
   import drik_pkg::*;
(
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [PosWidth-1:0]  pos_x,
   input  logic signed [PosWidth-1:0]  pos_y,
   input  logic signed [PosWidth-1:0]  pos_z,
   input  logic signed [PosWidth-1:0]  offset_a,
   input  logic signed [PosWidth-1:0]  offset_b,
   input  logic signed [PosWidth-1:0]  offset_c,
   input  logic [13:0]                 active_len,
   input  logic [14:0]                 passive_len,
   output arm_terms_type               arm_one,
   output arm_terms_type               arm_two,
   output arm_terms_type               arm_three
);

   // stage 1: offsets
   logic signed [15:0] d_ff, dx2_ff, dx3_ff, dy_ff, x_ff, z_ff;
   logic signed [14:0] l_ff;
   logic signed [15:0] p_ff;
   // stage 2: products
   logic signed [31:0] xx_ff, dd_ff, dx2sq_ff, dx3sq_ff, dysq_ff, zz_ff, ll_ff, pp_ff;
   logic signed [34:0] s2_ff, s3_ff;
   logic signed [34:0] u1_ff, v_ff;
   logic signed [14:0] l2_ff;
   // stage 3: final terms
   arm_terms_type a1_ff, a2_ff, a3_ff;

   logic signed [34:0] s2_in, s3_in;
   logic signed [55:0] q2, q3;
   logic signed [33:0] common;

   always_comb begin
      s2_in = 35'(Sqrt3Q16 * 35'(dx2_ff)) + (35'(dy_ff) <<< 16);
      s3_in = 35'(Sqrt3Q16 * 35'(dx3_ff)) - (35'(dy_ff) <<< 16);
      q2 = 56'(l2_ff) * 56'(s2_ff) + 56'sd32768;
      q3 = 56'(l2_ff) * 56'(s3_ff) + 56'sd32768;
      common = 34'(zz_ff) + 34'(ll_ff) - 34'(pp_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff   <= 16'(pos_y) + 16'(offset_a);
         dx2_ff <= 16'(pos_x) + 16'(offset_b);
         dx3_ff <= 16'(pos_x) - 16'(offset_b);
         dy_ff  <= 16'(pos_y) + 16'(offset_c);
         x_ff   <= 16'(pos_x);
         z_ff   <= 16'(pos_z);
         l_ff   <= signed'({1'b0, active_len});
         p_ff   <= signed'({1'b0, passive_len});

         xx_ff    <= 32'(x_ff) * 32'(x_ff);
         dd_ff    <= 32'(d_ff) * 32'(d_ff);
         dx2sq_ff <= 32'(dx2_ff) * 32'(dx2_ff);
         dx3sq_ff <= 32'(dx3_ff) * 32'(dx3_ff);
         dysq_ff  <= 32'(dy_ff) * 32'(dy_ff);
         zz_ff    <= 32'(z_ff) * 32'(z_ff);
         ll_ff    <= 32'(l_ff) * 32'(l_ff);
         pp_ff    <= 32'(p_ff) * 32'(p_ff);
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         u1_ff    <= (35'(l_ff) * 35'(d_ff)) <<< 1;
         v_ff     <= (35'(l_ff) * 35'(z_ff)) <<< 1;
         l2_ff    <= l_ff;

         a1_ff.u <= u1_ff;
         a1_ff.v <= v_ff;
         a1_ff.w <= 34'(xx_ff) + 34'(dd_ff) + common;
         a2_ff.u <= -35'(q2 >>> 16);
         a2_ff.v <= v_ff;
         a2_ff.w <= 34'(dx2sq_ff) + 34'(dysq_ff) + common;
         a3_ff.u <= 35'(q3 >>> 16);
         a3_ff.v <= v_ff;
         a3_ff.w <= 34'(dx3sq_ff) + 34'(dysq_ff) + common;
      end
   end

   assign arm_one   = a1_ff;
   assign arm_two   = a2_ff;
   assign arm_three = a3_ff;

endmodule

// ===== rtl/drik_arm.sv =====
//------------------------------------------------------------------------------
// drik_arm
// One arm: discriminant, pipelined integer square root, then pipelined CORDIC
// vectoring to the doubled half angle, saturated.
//------------------------------------------------------------------------------
module drik_arm
   import drik_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
)(
   input  logic                          clock,
   input  logic                          advance,
   input  arm_terms_type                 terms,
   output logic signed [AngleWidth-1:0]  angle,
   output logic                          bad
);

   localparam int RootSteps = RootWidth;

   // stage A: squares of the magnitudes
   logic [69:0] uu_ff, vv_ff;
   logic [67:0] ww_ff;
   logic signed [35:0] den_a_ff;
   logic signed [34:0] v_a_ff;
   logic [34:0] um, vm;
   logic [33:0] wm;

   always_comb begin
      um = terms.u[34] ? 35'(-terms.u) : 35'(terms.u);
      vm = terms.v[34] ? 35'(-terms.v) : 35'(terms.v);
      wm = terms.w[33] ? 34'(-terms.w) : 34'(terms.w);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         uu_ff    <= 70'(um) * 70'(um);
         vv_ff    <= 70'(vm) * 70'(vm);
         ww_ff    <= 68'(wm) * 68'(wm);
         den_a_ff <= 36'(terms.w) - 36'(terms.u);
         v_a_ff   <= terms.v;
      end
   end

   // stage B: discriminant and flags
   logic [71:0] disc_ff;
   logic        bad_b_ff;
   logic signed [35:0] den_b_ff;
   logic signed [34:0] v_b_ff;
   logic [71:0] sum_uv;

   assign sum_uv = 72'(uu_ff) + 72'(vv_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         disc_ff  <= sum_uv - 72'(ww_ff);
         bad_b_ff <= (72'(ww_ff) > sum_uv) || (den_a_ff == '0);
         den_b_ff <= den_a_ff;
         v_b_ff   <= v_a_ff;
      end
   end

   // square root: one result bit per stage
   logic [71:0]          rem_ff   [1:RootSteps];
   logic [RootWidth-1:0] root_ff  [1:RootSteps];
   logic signed [35:0]   den_r_ff [1:RootSteps];
   logic signed [34:0]   v_r_ff   [1:RootSteps];
   logic                 bad_r_ff [1:RootSteps];

   for (genvar k = 0; k < RootSteps; k++) begin : g_root
      localparam int B = RootSteps - 1 - k;
      logic [73:0] trial;
      logic [71:0] rem_sh;
      logic [RootWidth-1:0] root_sh;
      logic signed [35:0] den_sh;
      logic signed [34:0] v_sh;
      logic bad_sh;
      if (k == 0) begin : g_head
         assign rem_sh  = disc_ff;
         assign root_sh = '0;
         assign den_sh  = den_b_ff;
         assign v_sh    = v_b_ff;
         assign bad_sh  = bad_b_ff;
      end else begin : g_link
         assign rem_sh  = rem_ff[k];
         assign root_sh = root_ff[k];
         assign den_sh  = den_r_ff[k];
         assign v_sh    = v_r_ff[k];
         assign bad_sh  = bad_r_ff[k];
      end
      assign trial = {2'b0, ((72'(root_sh) << (B + 1)) | (72'(1) << (2 * B)))};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (74'(rem_sh) >= trial) begin
               rem_ff[k+1]  <= rem_sh - 72'(trial);
               root_ff[k+1] <= root_sh | (RootWidth'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_sh;
               root_ff[k+1] <= root_sh;
            end
            den_r_ff[k+1] <= den_sh;
            v_r_ff[k+1]   <= v_sh;
            bad_r_ff[k+1] <= bad_sh;
         end
      end
   end

   // numerator, sign fix
   logic signed [CordWidth-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CordWidth-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [ZWidth-1:0]    cz_ff [CORDIC_STEPS+1];
   logic                        bad_c_ff [CORDIC_STEPS+1];
   logic signed [CordWidth-1:0] num;
   logic signed [CordWidth-1:0] den;

   always_comb begin
      num = -CordWidth'(v_r_ff[RootSteps]) - CordWidth'({1'b0, root_ff[RootSteps]});
      den = CordWidth'(den_r_ff[RootSteps]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff[0]    <= den[CordWidth-1] ? -den : den;
         cy_ff[0]    <= den[CordWidth-1] ? -num : num;
         cz_ff[0]    <= '0;
         bad_c_ff[0] <= bad_r_ff[RootSteps];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam int Sh = (i < CordWidth) ? i : CordWidth - 1;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!cy_ff[i][CordWidth-1]) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> Sh);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> Sh);
               cz_ff[i+1] <= cz_ff[i] + atan_entry(i % MaxSteps);
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> Sh);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> Sh);
               cz_ff[i+1] <= cz_ff[i] - atan_entry(i % MaxSteps);
            end
            bad_c_ff[i+1] <= bad_c_ff[i];
         end
      end
   end

   logic signed [ZWidth-1:0] zr;
   logic signed [AngleWidth-1:0] ang_ff;
   logic bad_ff;

   assign zr = (cz_ff[CORDIC_STEPS] + ZWidth'(64)) >>> 7;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (zr > ZWidth'(AngleLimit))       ang_ff <= AngleWidth'(AngleLimit);
         else if (zr < -ZWidth'(AngleLimit)) ang_ff <= -AngleWidth'(AngleLimit);
         else                                ang_ff <= AngleWidth'(zr);
         bad_ff <= bad_c_ff[CORDIC_STEPS];
      end
   end

   assign angle = ang_ff;
   assign bad   = bad_ff;

endmodule

// ===== rtl/delta_robot_inverse_kinematics_unit.sv =====
//------------------------------------------------------------------------------
// delta_robot_inverse_kinematics_unit
// Fixed-point inverse kinematics for a three-arm delta robot.
//------------------------------------------------------------------------------
// Usage: write geometry over the csr_ channel while idle (index 0..4:
// offset_a, offset_b, offset_c, active link, passive link). Send positions on
// req_ (tdata = pos_x, pos_y, pos_z from bit 0, 15 bits each). Results leave
// on rsp_ (tdata = angle_one, angle_two, angle_three, 17 bits each from bit 0;
// tuser = unreachable).
// Throughput: one position per cycle while not stalled. Pipeline stages: 3 front,
// 2 discriminant, 36 square-root, CORDIC_STEPS + 2 CORDIC, set by the
// bit-per-stage root and one CORDIC step per stage.
// The whole pipe advances together; when rsp_tready is low and the output
// word is held, req_tready drops and nothing moves, so no word is lost.
// Reset clears valid bits and restores register defaults.
//------------------------------------------------------------------------------
module delta_robot_inverse_kinematics_unit
   import drik_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x, pos_y, pos_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // angle_one, angle_two, angle_three
   output logic        rsp_tuser,   // unreachable
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int Depth = 3 + 2 + RootWidth + CORDIC_STEPS + 2;

   logic signed [PosWidth-1:0] off_a_ff, off_b_ff, off_c_ff;
   logic [13:0] act_ff;
   logic [14:0] pas_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_a_ff <= '0;
         off_b_ff <= '0;
         off_c_ff <= '0;
         act_ff   <= 14'd2400;
         pas_ff   <= 15'd4800;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_A: off_a_ff <= csr_data[14:0];
            CSR_OFFSET_B: off_b_ff <= csr_data[14:0];
            CSR_OFFSET_C: off_c_ff <= csr_data[14:0];
            CSR_ACTIVE:   act_ff   <= csr_data[13:0];
            CSR_PASSIVE:  pas_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   logic advance;
   logic [Depth-1:0] vld_ff;

   // stall everything while the last word is held
   assign advance    = !(vld_ff[Depth-1] && !rsp_tready);
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
   end

   arm_terms_type t1, t2, t3;

   drik_front u_front (
      .clock       (clock),
      .advance     (advance),
      .pos_x       (req_tdata[14:0]),
      .pos_y       (req_tdata[29:15]),
      .pos_z       (req_tdata[44:30]),
      .offset_a    (off_a_ff),
      .offset_b    (off_b_ff),
      .offset_c    (off_c_ff),
      .active_len  (act_ff),
      .passive_len (pas_ff),
      .arm_one     (t1),
      .arm_two     (t2),
      .arm_three   (t3)
   );

   logic signed [AngleWidth-1:0] g1, g2, g3;
   logic b1, b2, b3, bad;

   drik_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm1 (
      .clock(clock), .advance(advance), .terms(t1), .angle(g1), .bad(b1));
   drik_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm2 (
      .clock(clock), .advance(advance), .terms(t2), .angle(g2), .bad(b2));
   drik_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm3 (
      .clock(clock), .advance(advance), .terms(t3), .angle(g3), .bad(b3));

   assign bad = b1 | b2 | b3;
   assign rsp_tuser = bad;
   assign rsp_tdata = bad ? 56'd0 : {5'd0, g3, g2, g1};

endmodule
